// ----- hw/rtl/mac_pkg.sv -----
// Shared types and constants for the magnetometer averaging and calibration block.
// Used by mac_lane, mac_ctrl, the top level and the checker; no dependencies.
package mac_pkg;

    localparam int RAW_W         = 16;
    localparam int AXES          = 3;
    localparam int DEF_AVG_DEPTH = 10;
    localparam int FRAC_BITS     = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_W         = 16;
    localparam int MODE_W        = 2;
    localparam int S_TDATA_W     = AXES * RAW_W;
    localparam int M_TDATA_W     = 3 * AXES * RAW_W;

    localparam logic signed [RAW_W-1:0] RAW_MIN          = 16'sh8000;
    localparam logic signed [RAW_W-1:0] RAW_MAX          = 16'sh7FFF;
    localparam logic signed [RAW_W-1:0] TRACK_HIGH_START = -16'sd5000;
    localparam logic signed [RAW_W-1:0] TRACK_LOW_START  = 16'sd5000;
    localparam logic [RAW_W-1:0]        UNITY_SCALE      = 16'd4096;
    localparam logic [FRAC_BITS-1:0]    FRAC_MASK        = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_START  = 2'd1,
        MODE_FINISH = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X = 3'd0,
        CFG_OFFSET_Y = 3'd1,
        CFG_OFFSET_Z = 3'd2,
        CFG_SCALE_X  = 3'd3,
        CFG_SCALE_Y  = 3'd4,
        CFG_SCALE_Z  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic  smp_accept;
        logic  ld2;
        logic  ld3;
        logic  ld4;
        logic  ld5;
        logic  retire;
        t_mode retire_mode;
        logic  tracking;
        logic  learned;
    } t_lane_ctl;

endpackage

// ----- hw/rtl/mac_lane.sv -----
// One axis lane: sample ring, running sum, reciprocal divide, offset and gain, extremes.
// Depends on mac_pkg; driven by the control struct from mac_ctrl.
module mac_lane #(
    parameter int AVG_DEPTH = mac_pkg::DEF_AVG_DEPTH,
    parameter bit NEGATE    = 1'b0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mac_pkg::t_lane_ctl                 i_ctl,
    input  logic signed [mac_pkg::RAW_W-1:0]   i_raw,
    input  logic signed [mac_pkg::RAW_W-1:0]   i_cfg_offset,
    input  logic        [mac_pkg::RAW_W-1:0]   i_cfg_scale,
    output logic signed [mac_pkg::RAW_W-1:0]   o_field,
    output logic signed [mac_pkg::RAW_W-1:0]   o_min,
    output logic signed [mac_pkg::RAW_W-1:0]   o_max
);
    import mac_pkg::*;

    localparam int DW  = $clog2(AVG_DEPTH);
    localparam int SW  = RAW_W + DW + 1;
    localparam int KSH = SW - 1 + DW;
    localparam longint unsigned RECIP = (64'd1 << KSH) / AVG_DEPTH + 64'd1;
    localparam int RW  = $clog2(RECIP + 64'd1);
    localparam int PW  = SW + RW;
    localparam int QW  = RAW_W + 1;
    localparam int MW  = QW + RAW_W;

    logic signed [RAW_W-1:0] r_ring [AVG_DEPTH];
    logic signed [SW-1:0]    r_sum;
    logic signed [SW-1:0]    n_sum;
    logic signed [RAW_W-1:0] w_val;

    logic [SW-1:0]           w_mag;
    logic [PW-1:0]           r_prod2;
    logic                    r_neg2;

    logic [QW-1:0]           w_q;
    logic signed [QW-1:0]    w_avg;
    logic signed [RAW_W-1:0] w_off;
    logic [RAW_W-1:0]        w_scl;
    logic signed [QW-1:0]    r_diff3;
    logic [RAW_W-1:0]        r_scl3;

    logic signed [MW-1:0]    r_prod4;
    logic signed [MW-1:0]    w_adj;
    logic signed [MW-1:0]    w_shq;
    logic signed [RAW_W-1:0] w_sat;
    logic signed [RAW_W-1:0] r_field5;

    logic signed [RAW_W-1:0] r_field_out;
    logic signed [RAW_W-1:0] r_min;
    logic signed [RAW_W-1:0] r_max;
    logic signed [RAW_W-1:0] r_learned;
    logic signed [QW-1:0]    w_pair;
    logic signed [QW-1:0]    w_mid;

    always_comb begin
        if (NEGATE) begin
            w_val = (i_raw == RAW_MIN) ? RAW_MAX : -i_raw;
        end else begin
            w_val = i_raw;
        end
        n_sum = r_sum + SW'(w_val) - SW'(r_ring[AVG_DEPTH-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AVG_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
            r_sum <= '0;
        end else if (i_ctl.smp_accept) begin
            r_ring[0] <= w_val;
            for (int i = 1; i < AVG_DEPTH; i++) begin
                r_ring[i] <= r_ring[i-1];
            end
            r_sum <= n_sum;
        end
    end

    // The running sum is divided by the ring depth through a rounded-up reciprocal,
    // applied to the magnitude so that the quotient truncates toward zero.
    assign w_mag = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_prod2 <= PW'(w_mag) * PW'(RECIP);
            r_neg2  <= r_sum[SW-1];
        end
    end

    always_comb begin
        w_q   = QW'(r_prod2 >> KSH);
        w_avg = r_neg2 ? -$signed(w_q) : $signed(w_q);
        w_off = i_ctl.learned ? r_learned : i_cfg_offset;
        w_scl = i_ctl.learned ? UNITY_SCALE : i_cfg_scale;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_diff3 <= w_avg - QW'(w_off);
            r_scl3  <= w_scl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld4) begin
            r_prod4 <= MW'(r_diff3) * MW'($signed({1'b0, r_scl3}));
        end
    end

    always_comb begin
        w_adj = r_prod4 + (r_prod4[MW-1] ? MW'(FRAC_MASK) : MW'(0));
        w_shq = w_adj >>> FRAC_BITS;
        if (w_shq > MW'(RAW_MAX)) begin
            w_sat = RAW_MAX;
        end else if (w_shq < MW'(RAW_MIN)) begin
            w_sat = RAW_MIN;
        end else begin
            w_sat = RAW_W'(w_shq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld5) begin
            r_field5 <= w_sat;
        end
    end

    always_comb begin
        w_pair = QW'(r_max) + QW'(r_min);
        w_mid  = (w_pair + (w_pair[QW-1] ? QW'(1) : QW'(0))) >>> 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.retire) begin
            r_field_out <= (i_ctl.retire_mode == MODE_SAMPLE) ? r_field5 : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min     <= '0;
            r_max     <= '0;
            r_learned <= '0;
        end else if (i_ctl.retire) begin
            case (i_ctl.retire_mode)
                MODE_SAMPLE: begin
                    if (i_ctl.tracking && (r_field5 < r_min)) begin
                        r_min <= r_field5;
                    end
                    if (i_ctl.tracking && (r_field5 > r_max)) begin
                        r_max <= r_field5;
                    end
                end
                MODE_START: begin
                    r_min <= TRACK_LOW_START;
                    r_max <= TRACK_HIGH_START;
                end
                MODE_FINISH: begin
                    r_learned <= RAW_W'(w_mid);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_field = r_field_out;
    assign o_min   = r_min;
    assign o_max   = r_max;

endmodule

// ----- hw/rtl/mac_ctrl.sv -----
// Pipeline control: stage valid bits, stall chain, word modes, tracking and learned flags.
// Depends on mac_pkg; feeds every mac_lane through a t_lane_ctl struct.
module mac_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  mac_pkg::t_mode      i_mode,
    input  logic                i_m_tready,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    output logic                o_tracking,
    output mac_pkg::t_lane_ctl  o_ctl
);
    import mac_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG:1] r_vld;
    t_mode         r_mode [1:NSTG-1];
    logic [NSTG:1] w_free;
    logic          w_fin_busy;
    logic          w_accept;
    logic          w_retire;
    logic          r_tracking;
    logic          r_learned;

    always_comb begin
        w_free[NSTG] = !r_vld[NSTG] || i_m_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_free[k] = !r_vld[k] || w_free[k+1];
        end
        w_fin_busy = 1'b0;
        for (int k = 1; k < NSTG; k++) begin
            w_fin_busy = w_fin_busy || (r_vld[k] && (r_mode[k] == MODE_FINISH));
        end
    end

    // A finish word holds off input until it has retired, so that later samples see the
    // learned offsets when they reach the offset stage.
    assign o_s_tready = w_free[1] && !w_fin_busy;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_retire   = r_vld[NSTG-1] && w_free[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_free[1]) begin
                r_vld[1] <= w_accept;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_free[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free[1]) begin
            r_mode[1] <= i_mode;
        end
        for (int k = 2; k < NSTG; k++) begin
            if (w_free[k]) begin
                r_mode[k] <= r_mode[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking <= 1'b0;
            r_learned  <= 1'b0;
        end else if (w_retire) begin
            case (r_mode[NSTG-1])
                MODE_START: begin
                    r_tracking <= 1'b1;
                end
                MODE_FINISH: begin
                    r_tracking <= 1'b0;
                    r_learned  <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_ctl.smp_accept  = w_accept && (i_mode == MODE_SAMPLE);
        o_ctl.ld2         = w_free[2];
        o_ctl.ld3         = w_free[3];
        o_ctl.ld4         = w_free[4];
        o_ctl.ld5         = w_free[5];
        o_ctl.retire      = w_retire;
        o_ctl.retire_mode = r_mode[NSTG-1];
        o_ctl.tracking    = r_tracking;
        o_ctl.learned     = r_learned;
    end

    assign o_m_tvalid = r_vld[NSTG];
    assign o_tracking = r_tracking;

endmodule

// ----- hw/rtl/magnetometer_average_and_calibrate.sv -----
// Stages: ring and sum, reciprocal product, offset, gain product, saturation, output register.
// Throughput: one word per cycle, set by the running sum per axis, while the output is not
// stalled; a finish word holds input off until it reaches the output register.
// Output register decouples the sides; input is taken while a result waits if a stage is free.
// Reset is synchronous and active low: pipeline emptied, rings and sums zeroed, extremes and
// learned offsets zeroed, offset registers set to 0 and scale registers to 4096.
module magnetometer_average_and_calibrate #(
    parameter int AVG_DEPTH = mac_pkg::DEF_AVG_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // raw_x, raw_y, raw_z
    input  logic [mac_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // mode
    input  logic [mac_pkg::MODE_W-1:0]        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // field_x, field_y, field_z, min_x, min_y, min_z, max_x, max_y, max_z
    output logic [mac_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // calibrating
    output logic                              o_m_tuser,
    input  logic                              i_cfg_we,
    input  logic [mac_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mac_pkg::CFG_W-1:0]         i_cfg_data
);
    import mac_pkg::*;

    logic signed [RAW_W-1:0] r_cfg_off [AXES];
    logic [RAW_W-1:0]        r_cfg_scl [AXES];
    t_lane_ctl               w_ctl;
    logic                    w_tracking;
    logic signed [RAW_W-1:0] w_field [AXES];
    logic signed [RAW_W-1:0] w_min   [AXES];
    logic signed [RAW_W-1:0] w_max   [AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_cfg_off[a] <= '0;
                r_cfg_scl[a] <= UNITY_SCALE;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OFFSET_X: r_cfg_off[0] <= i_cfg_data;
                CFG_OFFSET_Y: r_cfg_off[1] <= i_cfg_data;
                CFG_OFFSET_Z: r_cfg_off[2] <= i_cfg_data;
                CFG_SCALE_X:  r_cfg_scl[0] <= i_cfg_data;
                CFG_SCALE_Y:  r_cfg_scl[1] <= i_cfg_data;
                CFG_SCALE_Z:  r_cfg_scl[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_mode     (t_mode'(i_s_tuser)),
        .i_m_tready (i_m_tready),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_tracking (w_tracking),
        .o_ctl      (w_ctl)
    );

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        mac_lane #(
            .AVG_DEPTH (AVG_DEPTH),
            .NEGATE    (a != 2)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_raw        (i_s_tdata[a*RAW_W +: RAW_W]),
            .i_cfg_offset (r_cfg_off[a]),
            .i_cfg_scale  (r_cfg_scl[a]),
            .o_field      (w_field[a]),
            .o_min        (w_min[a]),
            .o_max        (w_max[a])
        );
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            o_m_tdata[a*RAW_W +: RAW_W]              = w_field[a];
            o_m_tdata[(AXES + a)*RAW_W +: RAW_W]     = w_min[a];
            o_m_tdata[(2*AXES + a)*RAW_W +: RAW_W]   = w_max[a];
        end
    end

    assign o_m_tuser = w_tracking;

endmodule

// ----- hw/rtl/mac_checker.sv -----
// Port-level checks for the magnetometer averaging and calibration block.
// Depends on mac_pkg; bound to magnetometer_average_and_calibrate below.
module mac_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [mac_pkg::MODE_W-1:0]        i_s_tuser,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [mac_pkg::M_TDATA_W-1:0]     o_m_tdata,
    input logic                              o_m_tuser
);
    import mac_pkg::*;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output word valid right after reset");

    a_finish_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == MODE_FINISH)) |=> !o_s_tready)
        else $error("word accepted behind a finish word still in flight");

    a_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled output word changed");

endmodule

bind magnetometer_average_and_calibrate mac_checker u_mac_checker (.*);

// ----- tb/sv/tb_magnetometer_average_and_calibrate.sv -----
// Self-checking testbench for magnetometer_average_and_calibrate: a stream driver and monitor,
// an internal model of the averaging rings, offset and gain correction and min/max tracking.
// Depends on mac_pkg and the top-level RTL module only.
module tb_magnetometer_average_and_calibrate;
    timeunit 1ns;
    timeprecision 1ps;
    import mac_pkg::*;

    localparam int AVG_DEPTH   = DEF_AVG_DEPTH;
    localparam int NUM_REGS    = 6;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 200;
    localparam logic [MODE_W-1:0]    MODE_IGNORED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [RAW_W-1:0]  raw_z;
        logic [RAW_W-1:0]  raw_y;
        logic [RAW_W-1:0]  raw_x;
    } t_word;

    typedef struct packed {
        logic                       calibrating;
        logic [AXES-1:0][RAW_W-1:0] max_v;
        logic [AXES-1:0][RAW_W-1:0] min_v;
        logic [AXES-1:0][RAW_W-1:0] field;
    } t_fields;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic [MODE_W-1:0]    i_s_tuser  = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    logic signed [RAW_W-1:0] ring [AXES][AVG_DEPTH];
    int                      ring_slot;
    logic                    tracking;
    logic signed [RAW_W-1:0] ext_lo [AXES];
    logic signed [RAW_W-1:0] ext_hi [AXES];
    logic signed [RAW_W-1:0] learned_off [AXES];
    logic                    learned;
    logic [CFG_W-1:0]        cfg_mirror [NUM_REGS];

    t_word   word_q[$];
    t_fields expected_q[$];
    string   axis_tag [AXES] = '{"x", "y", "z"};

    int words_queued = 0;
    int words_taken = 0;
    int results_checked = 0;
    int mismatches = 0;
    int n_samples = 0;
    int n_starts = 0;
    int n_finishes = 0;
    int n_ignored = 0;
    int n_settings = 0;
    int send_idle_pct = 7;
    int recv_idle_pct = 64;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit in_taken = 1'b0;
    int stall_cycles = 0;

    magnetometer_average_and_calibrate DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    function automatic logic signed [RAW_W-1:0] sat16(longint v);
        if (v > 32767) return RAW_MAX;
        if (v < -32768) return RAW_MIN;
        return 16'(v);
    endfunction

    function automatic logic [RAW_W-1:0] rnd16();
        return 16'($urandom);
    endfunction

    function automatic logic [RAW_W-1:0] near(int centre, int spread);
        return sat16(longint'(centre) + int'($urandom_range(2 * spread)) - spread);
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(9))
            0: return RAW_MIN;
            1: return RAW_MAX;
            2, 3, 4: return rnd16();
            default: return near(0, 3000);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_scale();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return rnd16();
            default: return near(int'(UNITY_SCALE), 1500);
        endcase
    endfunction

    // Advances the model by one accepted word and returns the result word it must produce.
    function automatic t_fields correct_and_track(t_word w);
        t_fields                 r;
        logic signed [RAW_W-1:0] raw [AXES];
        logic signed [RAW_W-1:0] f;
        int                      sum;
        int                      avg;
        int                      off;
        longint                  scl;
        r = '0;
        raw[0] = w.raw_x;
        raw[1] = w.raw_y;
        raw[2] = w.raw_z;
        if (w.mode == MODE_SAMPLE) begin
            for (int a = 0; a < AXES; a++)
                ring[a][ring_slot] = sat16((a < 2) ? -longint'(raw[a]) : longint'(raw[a]));
            ring_slot = (ring_slot + 1) % AVG_DEPTH;
            for (int a = 0; a < AXES; a++) begin
                sum = 0;
                for (int i = 0; i < AVG_DEPTH; i++)
                    sum += ring[a][i];
                avg = sum / AVG_DEPTH;
                if (learned) begin
                    off = learned_off[a];
                    scl = UNITY_SCALE;
                end else begin
                    off = $signed(cfg_mirror[int'(CFG_OFFSET_X) + a]);
                    scl = cfg_mirror[int'(CFG_SCALE_X) + a];
                end
                f = sat16(longint'(avg - off) * scl / 4096);
                r.field[a] = f;
                if (tracking) begin
                    if (f < ext_lo[a]) ext_lo[a] = f;
                    if (f > ext_hi[a]) ext_hi[a] = f;
                end
            end
        end else if (w.mode == MODE_START) begin
            tracking = 1'b1;
            for (int a = 0; a < AXES; a++) begin
                ext_hi[a] = TRACK_HIGH_START;
                ext_lo[a] = TRACK_LOW_START;
            end
        end else if (w.mode == MODE_FINISH) begin
            for (int a = 0; a < AXES; a++)
                learned_off[a] = 16'((int'(ext_hi[a]) + int'(ext_lo[a])) / 2);
            learned  = 1'b1;
            tracking = 1'b0;
        end
        for (int a = 0; a < AXES; a++) begin
            r.min_v[a] = ext_lo[a];
            r.max_v[a] = ext_hi[a];
        end
        r.calibrating = tracking;
        return r;
    endfunction

    function automatic void check_lane(string what, int a, logic [RAW_W-1:0] want,
                                       logic [RAW_W-1:0] got);
        if (got !== want) begin
            $error("%s_%s mismatch: expected %0d, got %0d", what, axis_tag[a],
                   $signed(want), $signed(got));
            mismatches++;
        end
    endfunction

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                for (int i = 0; i < AVG_DEPTH; i++)
                    ring[a][i] = '0;
                ext_lo[a]      = '0;
                ext_hi[a]      = '0;
                learned_off[a] = '0;
            end
            ring_slot = 0;
            tracking  = 1'b0;
            learned   = 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            expected_q.push_back(correct_and_track({i_s_tuser, i_s_tdata}));
            words_taken++;
            case (i_s_tuser)
                MODE_SAMPLE: n_samples++;
                MODE_START:  n_starts++;
                MODE_FINISH: n_finishes++;
                default:     n_ignored++;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_fields got;
        t_fields want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tuser, o_m_tdata};
            if (expected_q.size() == 0) begin
                $error("result word arrived with no prediction pending");
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                results_checked++;
                for (int a = 0; a < AXES; a++) begin
                    check_lane("field", a, want.field[a], got.field[a]);
                    check_lane("min", a, want.min_v[a], got.min_v[a]);
                    check_lane("max", a, want.max_v[a], got.max_v[a]);
                end
                if (got.calibrating !== want.calibrating) begin
                    $error("calibrating mismatch: expected %0d, got %0d",
                           want.calibrating, got.calibrating);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        t_word w;
        if (i_rst_n && (!i_s_tvalid || in_taken)) begin
            if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                w = word_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {w.raw_z, w.raw_y, w.raw_x};
                i_s_tuser  <= w.mode;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // One long output stall while the sender still has plenty queued, so the pipeline backs up.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && recv_idle_pct == 0 && word_q.size() > 100 && word_q.size() < 250)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("No word moved on either side for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_word(logic [MODE_W-1:0] mode, logic [RAW_W-1:0] x,
                             logic [RAW_W-1:0] y, logic [RAW_W-1:0] z);
        t_word w;
        w.mode  = mode;
        w.raw_x = x;
        w.raw_y = y;
        w.raw_z = z;
        word_q.push_back(w);
        words_queued++;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (words_taken != words_queued || expected_q.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx <= CFG_SCALE_Z) cfg_mirror[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_regs(logic [CFG_W-1:0] ox, logic [CFG_W-1:0] oy, logic [CFG_W-1:0] oz,
                             logic [CFG_W-1:0] sx, logic [CFG_W-1:0] sy, logic [CFG_W-1:0] sz);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_OFFSET_Z, oz);
        write_reg(CFG_SCALE_X, sx);
        write_reg(CFG_SCALE_Y, sy);
        write_reg(CFG_SCALE_Z, sz);
        write_reg(CFG_SPARE_LO, rnd16());
        write_reg(CFG_SPARE_HI, rnd16());
        n_settings++;
    endtask

    initial begin
        int roll;
        int centre;
        int chunk_end;
        for (int a = 0; a < AXES; a++) begin
            cfg_mirror[int'(CFG_OFFSET_X) + a] = '0;
            cfg_mirror[int'(CFG_SCALE_X) + a]  = UNITY_SCALE;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        load_regs(RAW_MAX, RAW_MIN, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        push_word(MODE_SAMPLE, RAW_MIN, RAW_MIN, RAW_MIN);
        push_word(MODE_SAMPLE, RAW_MAX, RAW_MAX, RAW_MAX);
        push_word(MODE_SAMPLE, RAW_MAX, RAW_MAX, RAW_MAX);
        push_word(MODE_SAMPLE, 16'd0, 16'd0, 16'd0);
        push_word(MODE_SAMPLE, -16'sd1, -16'sd1, -16'sd1);
        push_word(MODE_SAMPLE, 16'sd1, 16'sd1, 16'sd1);
        push_word(MODE_IGNORED, RAW_MIN, RAW_MAX, 16'h5555);
        push_word(MODE_START, RAW_MAX, 16'hAAAA, RAW_MIN);
        push_word(MODE_SAMPLE, RAW_MIN, RAW_MAX, RAW_MIN);
        push_word(MODE_SAMPLE, RAW_MAX, RAW_MIN, RAW_MAX);
        push_word(MODE_SAMPLE, 16'sd100, -16'sd100, 16'sd7);
        push_word(MODE_IGNORED, rnd16(), rnd16(), rnd16());
        push_word(MODE_START, rnd16(), rnd16(), rnd16());
        push_word(MODE_SAMPLE, 16'd0, 16'd0, 16'd0);

        for (int p = 0; p < 4; p++) begin
            drain();
            send_idle_pct = (p < 2) ? 7 : 64;
            recv_idle_pct = (p < 2) ? 64 : 7;
            if (p == 0)
                load_regs(RAW_MIN, RAW_MAX, RAW_MAX, 16'd0, 16'hFFFF, UNITY_SCALE);
            else
                load_regs(pick_raw(), pick_raw(), pick_raw(),
                          pick_scale(), pick_scale(), pick_scale());
            repeat (250) begin
                roll = $urandom_range(99);
                if (roll < 80)
                    push_word(MODE_SAMPLE, pick_raw(), pick_raw(), pick_raw());
                else if (roll < 88)
                    push_word(MODE_START, rnd16(), rnd16(), rnd16());
                else
                    push_word(MODE_IGNORED, rnd16(), rnd16(), rnd16());
            end
        end

        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // The first finish may arrive with tracking still armed from the phases above; the
        // second one has no start ahead of it and reuses the extremes already held.
        push_word(MODE_FINISH, rnd16(), rnd16(), rnd16());
        push_word(MODE_FINISH, rnd16(), rnd16(), rnd16());
        push_word(MODE_SAMPLE, 16'sd1000, -16'sd1000, 16'sd500);
        push_word(MODE_START, rnd16(), rnd16(), rnd16());
        push_word(MODE_SAMPLE, -16'sd6000, 16'sd6000, 16'sd6000);
        push_word(MODE_SAMPLE, 16'sd6000, -16'sd6000, -16'sd6000);
        push_word(MODE_FINISH, rnd16(), rnd16(), rnd16());
        push_word(MODE_SAMPLE, 16'd0, 16'd0, 16'd0);

        for (int c = 0; c < 2; c++) begin
            drain();
            // Learned offsets are in force from here on, so these writes must change nothing.
            if (c == 1)
                load_regs(pick_raw(), pick_raw(), pick_raw(),
                          pick_scale(), pick_scale(), pick_scale());
            chunk_end = words_queued + 420;
            while (words_queued < chunk_end) begin
                roll = $urandom_range(99);
                if (roll < 80) begin
                    centre = int'($urandom_range(12000)) - 6000;
                    push_word(MODE_START, rnd16(), rnd16(), rnd16());
                    repeat ($urandom_range(40, 5))
                        push_word(MODE_SAMPLE, near(centre, 4000), near(-centre, 4000),
                                  near(centre / 2, 6000));
                    push_word(MODE_FINISH, rnd16(), rnd16(), rnd16());
                    repeat ($urandom_range(15))
                        push_word(MODE_SAMPLE, near(centre, 3000), near(-centre, 3000),
                                  near(0, 3000));
                end else begin
                    case (roll % 4)
                        0: push_word(MODE_IGNORED, rnd16(), rnd16(), rnd16());
                        1: push_word(MODE_FINISH, rnd16(), rnd16(), rnd16());
                        2: push_word(MODE_START, rnd16(), rnd16(), rnd16());
                        default: push_word(MODE_SAMPLE, pick_raw(), pick_raw(), pick_raw());
                    endcase
                end
            end
        end

        drain();
        repeat (12) @(posedge i_clk);
        $display("Checked %0d result words from %0d samples, %0d starts, %0d finishes, %0d mode-3 words.",
                 results_checked, n_samples, n_starts, n_finishes, n_ignored);
        $display("Register sets loaded: %0d, covering offset and gain extremes and post-calibration writes.",
                 n_settings);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
